>>> rtl/tpdc_pkg.sv
// Shared types and constants for the tag presence door controller.
`default_nettype none

package tpdc_pkg;

  // Slot count of the tag whitelist when the top level is not overridden.
  localparam int unsigned TAG_SLOTS_DEFAULT = 8;

  // Depth of the queue between the request decoder and the executor.
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0]  CODE_LEN      = 8'd12;
  localparam logic [11:0] PULSE_OPEN    = 12'd2500;
  localparam logic [11:0] PULSE_CLOSED  = 12'd500;
  localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

  // Request codes as they arrive on req_type_i.
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_DETECT = 2'd1;
  localparam logic [1:0] REQ_CHECK  = 2'd2;

  // Operation after decoding; OP_NONE covers rejected lengths and unknown requests.
  typedef enum logic [1:0] {
    OP_ADD,
    OP_DETECT,
    OP_CHECK,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] tag_high;
    logic [63:0] tag_low;
    logic [31:0] time_ms;
  } entry_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] idx;
    logic       door;
    logic       any;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/tpdc_front.sv
// Request decoder and the short queue that feeds the executor.
`default_nettype none

module tpdc_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  output logic                busy_o,
  input  wire  [1:0]          req_type_i,
  input  wire  [31:0]         tag_high_i,
  input  wire  [63:0]         tag_low_i,
  input  wire  [7:0]          tag_length_i,
  input  wire  [31:0]         time_ms_i,
  output logic                q_valid_o,
  output tpdc_pkg::entry_t    q_entry_o,
  input  wire                 q_pop_i
);

  localparam int unsigned QPTR_W = (tpdc_pkg::QUEUE_DEPTH > 1) ?
                                   $clog2(tpdc_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(tpdc_pkg::QUEUE_DEPTH + 1);
  localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(tpdc_pkg::QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(tpdc_pkg::QUEUE_DEPTH);

  tpdc_pkg::entry_t          slot_q [tpdc_pkg::QUEUE_DEPTH];
  tpdc_pkg::entry_t          entry;
  logic [QPTR_W-1:0]         wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]         rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]         cnt_q, cnt_d;
  logic                      push;
  logic                      pop;

  // Decode the request; a wrong length turns add and detect into a no-op.
  always_comb begin
    entry.tag_high = tag_high_i;
    entry.tag_low  = tag_low_i;
    entry.time_ms  = time_ms_i;
    unique case (req_type_i)
      tpdc_pkg::REQ_ADD: begin
        entry.op = (tag_length_i == tpdc_pkg::CODE_LEN) ? tpdc_pkg::OP_ADD :
                                                          tpdc_pkg::OP_NONE;
      end
      tpdc_pkg::REQ_DETECT: begin
        entry.op = (tag_length_i == tpdc_pkg::CODE_LEN) ? tpdc_pkg::OP_DETECT :
                                                          tpdc_pkg::OP_NONE;
      end
      tpdc_pkg::REQ_CHECK: begin
        entry.op = tpdc_pkg::OP_CHECK;
      end
      default: begin
        entry.op = tpdc_pkg::OP_NONE;
      end
    endcase
  end

  assign busy_o    = (cnt_q == FULL_CNT);
  assign push      = start_i && !busy_o;
  assign q_valid_o = (cnt_q != '0);
  assign pop       = q_pop_i && q_valid_o;
  assign q_entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= entry;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tpdc_back.sv
// Executor: tag and time memories, presence flags, door state and result register.
`default_nettype none

module tpdc_back #(
  parameter int unsigned TAG_SLOTS = tpdc_pkg::TAG_SLOTS_DEFAULT
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 q_valid_i,
  input  wire tpdc_pkg::entry_t q_entry_i,
  output logic                q_pop_o,
  input  wire  [31:0]         timeout_i,
  output logic                res_valid_o,
  output tpdc_pkg::result_t   res_o
);

  localparam int unsigned IDX_W = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(TAG_SLOTS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TAG_SLOTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DET  = 2'd1;
  localparam logic [1:0] ST_CHK  = 2'd2;

  logic [95:0]            tag_mem [TAG_SLOTS];
  logic [31:0]            time_mem [TAG_SLOTS];
  logic [95:0]            tag_rd_q;
  logic [31:0]            time_rd_q;

  logic [1:0]             state_q, state_d;
  logic [CNT_W-1:0]       scan_q, scan_d;
  logic                   pend_q, pend_d;
  logic                   still_q, still_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [TAG_SLOTS-1:0]   present_q, present_d;
  logic                   door_q, door_d;
  tpdc_pkg::entry_t       cur_q, cur_d;
  logic                   res_valid_d;
  tpdc_pkg::result_t      res_q, res_d;

  logic                   issue;
  logic [IDX_W-1:0]       rd_idx;
  logic [IDX_W-1:0]       cmp_idx;
  logic [IDX_W-1:0]       add_idx;
  logic                   tag_we;
  logic                   time_we;
  logic [31:0]            age;

  assign issue   = (scan_q < count_q);
  assign rd_idx  = scan_q[IDX_W-1:0];
  // Read data is registered, so it belongs to the slot addressed in the previous cycle.
  assign cmp_idx = IDX_W'(scan_q - CNT_W'(1));
  assign add_idx = IDX_W'(count_q);
  assign age     = cur_q.time_ms - time_rd_q;

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    pend_d      = 1'b0;
    still_d     = still_q;
    count_d     = count_q;
    present_d   = present_q;
    door_d      = door_q;
    cur_d       = cur_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    tag_we      = 1'b0;
    time_we     = 1'b0;
    q_pop_o     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_entry_i;
          case (q_entry_i.op)
            tpdc_pkg::OP_ADD: begin
              res_valid_d = 1'b1;
              if (count_q < FULL_CNT) begin
                tag_we             = 1'b1;
                present_d[add_idx] = 1'b0;
                count_d            = count_q + CNT_W'(1);
                res_d.ok           = 1'b1;
                res_d.idx          = 3'(count_q);
              end
            end
            tpdc_pkg::OP_DETECT: begin
              state_d = ST_DET;
              scan_d  = '0;
            end
            tpdc_pkg::OP_CHECK: begin
              state_d = ST_CHK;
              scan_d  = '0;
              still_d = 1'b0;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end

      ST_DET: begin
        pend_d = issue;
        if (issue) begin
          scan_d = scan_q + CNT_W'(1);
        end
        if (pend_q && (tag_rd_q == {cur_q.tag_high, cur_q.tag_low})) begin
          // The lowest matching slot wins, since slots are visited in order.
          state_d            = ST_IDLE;
          res_valid_d        = 1'b1;
          present_d[cmp_idx] = 1'b1;
          time_we            = 1'b1;
          door_d             = 1'b1;
          res_d.ok           = 1'b1;
          res_d.idx          = 3'(cmp_idx);
        end else if (!pend_q && !issue) begin
          state_d     = ST_IDLE;
          res_valid_d = 1'b1;
        end
      end

      ST_CHK: begin
        pend_d = issue;
        if (issue) begin
          scan_d = scan_q + CNT_W'(1);
        end
        if (pend_q && present_q[cmp_idx]) begin
          if (age > timeout_i) begin
            present_d[cmp_idx] = 1'b0;
          end else begin
            still_d = 1'b1;
          end
        end
        if (!pend_q && !issue) begin
          state_d     = ST_IDLE;
          res_valid_d = 1'b1;
          res_d.ok    = 1'b1;
          if (!still_q) begin
            door_d = 1'b0;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_d.door = door_d;
    // Flags above the fill count are never set, so the whole vector can be reduced.
    res_d.any  = |present_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      still_q     <= 1'b0;
      count_q     <= '0;
      present_q   <= '0;
      door_q      <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      still_q     <= still_d;
      count_q     <= count_d;
      present_q   <= present_d;
      door_q      <= door_d;
      res_valid_o <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[add_idx] <= {q_entry_i.tag_high, q_entry_i.tag_low};
    end
    tag_rd_q <= tag_mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (time_we) begin
      time_mem[cmp_idx] <= cur_q.time_ms;
    end
    time_rd_q <= time_mem[rd_idx];
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

>>> rtl/tag_presence_door_control.sv
// Top level of the tag presence door controller: timeout register, decoder, executor.
//
//  Channel   Ports                                     Handshake
//  request   req_type_i tag_high_i tag_low_i           start_i high, busy_o low
//            tag_length_i time_ms_i
//  result    request_ok_o tag_index_o door_open_o      result_valid_o, one cycle
//            servo_pulse_us_o any_tag_present_o
//  config    cfg_wdata_i (presence timeout, ms)        cfg_we_i
//
// An add or a rejected request is answered when the executor takes it from the queue.
// A detect or a timeout check visits the filled slots one per cycle through the single
// read port of the tag and time memories and answers when the scan ends or a detect matches.
// A two-beat queue between decoder and executor lets requests be taken while one executes;
// busy_o rises only when that queue is full. Results cannot be stalled.
// Reset clears the fill count, presence flags and door state; the timeout returns to 5000.
`default_nettype none

module tag_presence_door_control #(
  parameter int unsigned TAG_SLOTS = tpdc_pkg::TAG_SLOTS_DEFAULT
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          start_i,
  output logic         busy_o,
  input  wire  [1:0]   req_type_i,
  input  wire  [31:0]  tag_high_i,
  input  wire  [63:0]  tag_low_i,
  input  wire  [7:0]   tag_length_i,
  input  wire  [31:0]  time_ms_i,
  input  wire          cfg_we_i,
  input  wire  [31:0]  cfg_wdata_i,
  output logic         result_valid_o,
  output logic         request_ok_o,
  output logic [2:0]   tag_index_o,
  output logic         door_open_o,
  output logic [11:0]  servo_pulse_us_o,
  output logic         any_tag_present_o
);

  logic [31:0]          timeout_q;
  logic                 q_valid;
  tpdc_pkg::entry_t     q_entry;
  logic                 q_pop;
  tpdc_pkg::result_t    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= tpdc_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  tpdc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .tag_high_i   (tag_high_i),
    .tag_low_i    (tag_low_i),
    .tag_length_i (tag_length_i),
    .time_ms_i    (time_ms_i),
    .q_valid_o    (q_valid),
    .q_entry_o    (q_entry),
    .q_pop_i      (q_pop)
  );

  tpdc_back #(
    .TAG_SLOTS (TAG_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .timeout_i   (timeout_q),
    .res_valid_o (result_valid_o),
    .res_o       (res)
  );

  assign request_ok_o      = res.ok;
  assign tag_index_o       = res.idx;
  assign door_open_o       = res.door;
  assign servo_pulse_us_o  = res.door ? tpdc_pkg::PULSE_OPEN : tpdc_pkg::PULSE_CLOSED;
  assign any_tag_present_o = res.any;

  // A rejected request never reports a slot.
  a_idx_zero_when_rejected: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !request_ok_o) |-> (tag_index_o == 3'd0)
  ) else $error("rejected request reports a nonzero slot");

  // A present tag was set by a detect that opened the door, and only a check
  // that finds no tag present closes it.
  a_present_implies_open: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && any_tag_present_o) |-> door_open_o
  ) else $error("tag present while door closed");

  // The queue cannot leave busy without the executor having drained a beat.
  a_busy_release: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (busy_o && !q_pop) |=> busy_o
  ) else $error("busy dropped without a queue pop");

endmodule

`default_nettype wire
